FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the pressure filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/pzc_pkg.sv
// shared types and constants of the pressure zero-cal ema filter
`default_nettype none

package pzc_pkg;

    localparam int SAMPLE_BITS = 20;
    localparam int CNT_W       = 10;
    localparam int SUM_W       = 30;
    localparam int OFS_FRAC_W  = 8;
    localparam int OFS_W       = 28;
    localparam int DIFF_W      = OFS_W + 1;
    localparam int PRESS_W     = 29;
    localparam int GAIN_W      = 32;
    localparam int ALPHA_W     = 17;
    localparam int DVD_W       = SUM_W + OFS_FRAC_W;
    localparam int DIV_STEPS   = DVD_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int PROD_W      = OFS_W + GAIN_W;
    localparam int SCALE_SHIFT = 24;
    localparam int RND_W       = PROD_W - SCALE_SHIFT;
    localparam int EMA_SHIFT   = 16;
    localparam int P_W         = PRESS_W + ALPHA_W + 1;
    localparam int ACC_W       = P_W + 1;
    localparam int Q_W         = ACC_W - EMA_SHIFT;

    localparam int IN_DATA_W   = 24;
    localparam int IN_USER_W   = 1;
    localparam int OUT_DATA_W  = 32;
    localparam int OUT_USER_W  = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 2'd2;

    localparam logic [CNT_W-1:0]   RST_CAL_SAMPLES = 10'd101;
    localparam logic [GAIN_W-1:0]  RST_GAIN        = 32'd12204965;
    localparam logic [ALPHA_W-1:0] RST_ALPHA       = 17'd5243;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE       = 17'h10000;

    localparam logic [RND_W-1:0] SCALE_POS_LIM = RND_W'((64'd1 << (PRESS_W - 1)) - 64'd1);
    localparam logic [RND_W-1:0] SCALE_NEG_LIM = RND_W'(64'd1 << (PRESS_W - 1));
    localparam logic signed [PRESS_W-1:0] PRESS_MAX = {1'b0, {(PRESS_W-1){1'b1}}};
    localparam logic signed [PRESS_W-1:0] PRESS_MIN = {1'b1, {(PRESS_W-1){1'b0}}};

    typedef struct packed {
        logic capture;
        logic cal_step;
        logic div_step;
        logic div_finish;
        logic diff;
        logic scale;
        logic sat;
        logic ema_a;
        logic ema_b;
        logic ema_sum;
        logic ema_round;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic ch_ok;
        logic cal_done;
        logic cal_reached;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/pzc_ctrl.sv
// sequencer of the pressure zero-cal ema filter
`default_nettype none
`include "assert_macros.svh"

module pzc_ctrl
    import pzc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_DIV      = 4'd2;
    localparam logic [3:0] S_OFS      = 4'd3;
    localparam logic [3:0] S_SCALE    = 4'd4;
    localparam logic [3:0] S_SAT      = 4'd5;
    localparam logic [3:0] S_EMA_A    = 4'd6;
    localparam logic [3:0] S_EMA_B    = 4'd7;
    localparam logic [3:0] S_SUM      = 4'd8;
    localparam logic [3:0] S_RND      = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [3:0]           r_state;
    logic [3:0]           n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DIV_CNT_W-1:0] n_div_cnt;

    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && o_s_tready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_stat.ch_ok) begin
                    n_state = S_OUT;
                end else if (!i_stat.cal_done) begin
                    o_cmd.cal_step = 1'b1;
                    n_state        = i_stat.cal_reached ? S_DIV : S_OUT;
                end else begin
                    o_cmd.diff = 1'b1;
                    n_state    = S_SCALE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    n_div_cnt = '0;
                    n_state   = S_OFS;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            S_OFS: begin
                o_cmd.div_finish = 1'b1;
                n_state          = S_OUT;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_SAT;
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = S_EMA_A;
            end
            S_EMA_A: begin
                o_cmd.ema_a = 1'b1;
                n_state     = S_EMA_B;
            end
            S_EMA_B: begin
                o_cmd.ema_b = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.ema_sum = 1'b1;
                n_state       = S_RND;
            end
            S_RND: begin
                o_cmd.ema_round = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    `ASSERT_CLK(a_div_cnt_idle, i_clk, i_rst_n, (r_state != S_DIV) |-> (r_div_cnt == '0), "divider count left running")
    `ASSERT_CLK(a_accept_dispatch, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> (r_state == S_DISPATCH), "accepted word not dispatched")
    `ASSERT_NEVER(a_load_busy, i_clk, i_rst_n, o_cmd.out_load && i_stat.out_busy, "output register overwritten")

endmodule

`default_nettype wire

FILE: hw/rtl/pzc_dp.sv
// datapath of the pressure zero-cal ema filter: state, divider, multiplier, output register
`default_nettype none
`include "assert_macros.svh"

module pzc_dp
    import pzc_pkg::*;
#(
    parameter int CHANNELS = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic [IN_USER_W-1:0]  i_s_tuser,
    input  wire logic                  i_m_tready,
    output logic                       o_m_tvalid,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    output logic [OUT_USER_W-1:0]      o_m_tuser,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CNT_W-1:0]   r_cal_samples;
    logic [GAIN_W-1:0]  r_gain;
    logic [ALPHA_W-1:0] r_alpha;

    logic                   r_ch;
    logic [SAMPLE_BITS-1:0] r_smp;

    logic                       r_cal_done  [CHANNELS];
    logic [CNT_W-1:0]           r_cal_count [CHANNELS];
    logic [SUM_W-1:0]           r_cal_sum   [CHANNELS];
    logic [OFS_W-1:0]           r_zero_ofs  [CHANNELS];
    logic signed [PRESS_W-1:0]  r_filt      [CHANNELS];

    logic [DVD_W-1:0] r_dvd;
    logic [CNT_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_rem;

    logic [OFS_W-1:0]          r_mag;
    logic                      r_neg;
    logic [PROD_W-1:0]         r_prod;
    logic signed [PRESS_W-1:0] r_x;
    logic signed [P_W-1:0]     r_p1;
    logic signed [P_W-1:0]     r_p2;
    logic signed [ACC_W-1:0]   r_acc;

    logic                      r_out_valid;
    logic                      r_out_ch;
    logic                      r_out_cal;
    logic signed [PRESS_W-1:0] r_out_press;

    logic [CH_IDX_W-1:0]       w_idx;
    logic                      w_ch_ok;
    logic                      w_cur_done;
    logic [CNT_W-1:0]          w_need;
    logic [CNT_W-1:0]          w_new_count;
    logic [SUM_W-1:0]          w_new_sum;
    logic                      w_reached;
    logic [CNT_W:0]            w_rem_sh;
    logic [CNT_W:0]            w_rem_sub;
    logic                      w_qbit;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [DIFF_W-1:0]  w_diff_neg;
    logic [PROD_W-1:0]         w_rsum;
    logic [RND_W-1:0]          w_r;
    logic signed [PRESS_W-1:0] w_r_neg;
    logic signed [PRESS_W-1:0] w_x;
    logic [ALPHA_W-1:0]        w_a;
    logic signed [ALPHA_W:0]   w_a_s;
    logic signed [ALPHA_W:0]   w_b_s;
    logic signed [ACC_W-1:0]   w_rnd;
    logic signed [Q_W-1:0]     w_q;
    logic signed [PRESS_W-1:0] w_filt_new;

    assign w_idx      = CH_IDX_W'(r_ch);
    assign w_ch_ok    = (int'(r_ch) < CHANNELS);
    assign w_cur_done = r_cal_done[w_idx];

    assign w_need      = (r_cal_samples == '0) ? CNT_W'(1) : r_cal_samples;
    assign w_new_count = r_cal_count[w_idx] + 1'b1;
    assign w_new_sum   = r_cal_sum[w_idx] + SUM_W'(r_smp);
    assign w_reached   = (w_new_count >= w_need);

    // restoring divider, one quotient bit per step
    assign w_rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_dvs};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_dvs});

    assign w_diff     = $signed({1'b0, r_smp, {OFS_FRAC_W{1'b0}}}) - $signed({1'b0, r_zero_ofs[w_idx]});
    assign w_diff_neg = -w_diff;

    // round to nearest, ties away, then saturate
    assign w_rsum  = r_prod + (PROD_W'(1) << (SCALE_SHIFT - 1));
    assign w_r     = w_rsum[PROD_W-1:SCALE_SHIFT];
    assign w_r_neg = -$signed(w_r[PRESS_W-1:0]);

    always_comb begin
        if (!r_neg) begin
            w_x = (w_r > SCALE_POS_LIM) ? PRESS_MAX : $signed(w_r[PRESS_W-1:0]);
        end else begin
            w_x = (w_r > SCALE_NEG_LIM) ? PRESS_MIN : w_r_neg;
        end
    end

    assign w_a   = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign w_a_s = $signed({1'b0, w_a});
    assign w_b_s = $signed({1'b0, ALPHA_ONE - w_a});

    assign w_rnd = r_acc + ACC_W'(1 << (EMA_SHIFT - 1)) - ACC_W'(r_acc[ACC_W-1]);
    assign w_q   = w_rnd[ACC_W-1:EMA_SHIFT];

    always_comb begin
        if (w_q > Q_W'(PRESS_MAX)) begin
            w_filt_new = PRESS_MAX;
        end else if (w_q < Q_W'(PRESS_MIN)) begin
            w_filt_new = PRESS_MIN;
        end else begin
            w_filt_new = w_q[PRESS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_samples <= RST_CAL_SAMPLES;
            r_gain        <= RST_GAIN;
            r_alpha       <= RST_ALPHA;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAL_SAMPLES: r_cal_samples <= i_cfg_data[CNT_W-1:0];
                CFG_GAIN:        r_gain        <= i_cfg_data[GAIN_W-1:0];
                CFG_ALPHA:       r_alpha       <= i_cfg_data[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_cal_done[i]  <= 1'b0;
                r_cal_count[i] <= '0;
                r_cal_sum[i]   <= '0;
                r_zero_ofs[i]  <= '0;
                r_filt[i]      <= '0;
            end
        end else if (w_ch_ok) begin
            if (i_cmd.cal_step) begin
                if (w_reached) begin
                    r_cal_count[w_idx] <= '0;
                    r_cal_sum[w_idx]   <= '0;
                    r_filt[w_idx]      <= '0;
                    r_cal_done[w_idx]  <= 1'b1;
                end else begin
                    r_cal_count[w_idx] <= w_new_count;
                    r_cal_sum[w_idx]   <= w_new_sum;
                end
            end
            if (i_cmd.div_finish) begin
                r_zero_ofs[w_idx] <= r_dvd[OFS_W-1:0];
            end
            if (i_cmd.ema_round) begin
                r_filt[w_idx] <= w_filt_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ch  <= i_s_tuser[0];
            r_smp <= i_s_tdata[SAMPLE_BITS-1:0];
        end
        if (i_cmd.cal_step) begin
            r_dvd <= {w_new_sum, {OFS_FRAC_W{1'b0}}} + DVD_W'(w_new_count >> 1);
            r_dvs <= w_new_count;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DVD_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_rem_sub[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
        end
        if (i_cmd.diff) begin
            r_neg <= w_diff[DIFF_W-1];
            r_mag <= w_diff[DIFF_W-1] ? w_diff_neg[OFS_W-1:0] : w_diff[OFS_W-1:0];
        end
        if (i_cmd.scale) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(r_gain);
        end
        if (i_cmd.sat) begin
            r_x <= w_x;
        end
        if (i_cmd.ema_a) begin
            r_p1 <= P_W'(r_x) * P_W'(w_a_s);
        end
        if (i_cmd.ema_b) begin
            r_p2 <= P_W'(r_filt[w_idx]) * P_W'(w_b_s);
        end
        if (i_cmd.ema_sum) begin
            r_acc <= ACC_W'(r_p1) + ACC_W'(r_p2);
        end
        if (i_cmd.out_load) begin
            r_out_ch    <= r_ch;
            r_out_cal   <= w_ch_ok && w_cur_done;
            r_out_press <= w_ch_ok ? r_filt[w_idx] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.ch_ok       = w_ch_ok;
    assign o_stat.cal_done    = w_cur_done;
    assign o_stat.cal_reached = w_reached;
    assign o_stat.out_busy    = r_out_valid && !i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'(unsigned'(r_out_press));
    assign o_m_tuser  = {r_out_cal, r_out_ch};

    `ASSERT_CLK(a_cal_done_sticky, i_clk, i_rst_n, ($past(i_rst_n) && $past(r_cal_done[0])) |-> r_cal_done[0], "calibration flag cleared")
    `ASSERT_NEVER(a_ema_uncal, i_clk, i_rst_n, i_cmd.ema_round && !w_cur_done, "filter run on uncalibrated channel")
    `ASSERT_CLK(a_div_rem_range, i_clk, i_rst_n, i_cmd.div_step |-> ({1'b0, r_rem} < {1'b0, r_dvs}), "divider remainder out of range")

endmodule

`default_nettype wire

FILE: hw/rtl/pressure_zero_cal_ema_filter.sv
// pressure front end: per-channel zero-offset calibration and ema filter
//
// usage
//   input words on the s_axis group: tdata carries the raw 20-bit adc sample,
//   tuser the channel. one result word per input on the m_axis group: tdata
//   carries the filtered pressure (signed, 8 fraction bits, mmHg), tuser the
//   channel and the calibrated flag.
//   the cfg channel writes calibration_samples (index 0), count_to_mmhg_gain
//   (index 1) and ema_alpha (index 2); write only while no word is in flight.
//   a word is taken when tready is high, which is only between words. a
//   calibration sample passes dispatch and output, the sample that completes
//   calibration also runs a 38-step serial divider that forms the offset, and a
//   filtered sample runs three multiply steps in sequence.
//   a result waiting in the output register does not block the next word; a
//   finished word holds in the sequencer while the receiver stalls.
//   reset restores register defaults, clears every channel to uncalibrated
//   with zero offset and zero pressure, and empties the output register.
`default_nettype none

module pressure_zero_cal_ema_filter
    import pzc_pkg::*;
#(
    parameter int CHANNELS = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [19:0] sample
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,   // [0] channel
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,   // [28:0] pressure
    output logic [OUT_USER_W-1:0]      o_m_axis_tuser,   // [0] out_channel, [1] calibrated
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = i_rst_n;

    pzc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pzc_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

`default_nettype wire

FILE: dv/pressure_zero_cal_ema_filter_test.sv
// testbench for the pressure zero-cal ema filter: directed and random words, scoreboard check
`timescale 1ns / 100ps

module pressure_zero_cal_ema_filter_test
    import pzc_pkg::*;
();

    localparam int NUM_CH       = 2;
    localparam int SETTLE_WAIT  = 50;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_WORDS  = 160;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    typedef struct packed {
        logic                      ch;
        logic                      cal;
        logic signed [PRESS_W-1:0] press;
    } t_reading;

    class pressure_tracker;
        logic [CNT_W-1:0]          cal_target;
        logic [GAIN_W-1:0]         gain;
        logic [ALPHA_W-1:0]        alpha;
        bit                        cal_flag[NUM_CH];
        logic [CNT_W-1:0]          cal_cnt[NUM_CH];
        logic [SUM_W-1:0]          cal_acc[NUM_CH];
        logic [OFS_W-1:0]          zero_ofs[NUM_CH];
        logic signed [PRESS_W-1:0] level[NUM_CH];
        t_reading                  pending[$];
        int                        errors;

        function new();
            cal_target = RST_CAL_SAMPLES;
            gain       = RST_GAIN;
            alpha      = RST_ALPHA;
            errors     = 0;
            for (int i = 0; i < NUM_CH; i++) begin
                cal_flag[i] = 1'b0;
                cal_cnt[i]  = '0;
                cal_acc[i]  = '0;
                zero_ofs[i] = '0;
                level[i]    = '0;
            end
        endfunction

        function void load_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_CAL_SAMPLES: cal_target = value[CNT_W-1:0];
                CFG_GAIN:        gain = value[GAIN_W-1:0];
                CFG_ALPHA:       alpha = value[ALPHA_W-1:0];
                default:         ;
            endcase
        endfunction

        function longint clamp_press(input longint v);
            if (v > longint'(PRESS_MAX)) return longint'(PRESS_MAX);
            if (v < longint'(PRESS_MIN)) return longint'(PRESS_MIN);
            return v;
        endfunction

        function void note_sample(input logic ch, input logic [SAMPLE_BITS-1:0] smp);
            logic [CNT_W-1:0]  need;
            longint unsigned   n, total, mag, r;
            longint            a, diff, x, acc, q;
            t_reading          word;
            if (!cal_flag[ch]) begin
                need = (cal_target == '0) ? CNT_W'(1) : cal_target;
                cal_cnt[ch] = cal_cnt[ch] + 1'b1;
                cal_acc[ch] = cal_acc[ch] + SUM_W'(smp);
                if (cal_cnt[ch] >= need) begin
                    n = cal_cnt[ch];
                    total = cal_acc[ch];
                    zero_ofs[ch] = OFS_W'(((total << 8) + n / 2) / n);
                    cal_cnt[ch]  = '0;
                    cal_acc[ch]  = '0;
                    level[ch]    = '0;
                    cal_flag[ch] = 1'b1;
                end
            end else begin
                if (alpha > ALPHA_ONE) a = 65536;
                else a = longint'(alpha);
                diff = longint'(smp) * 256 - longint'(zero_ofs[ch]);
                mag = (diff < 0) ? -diff : diff;
                r = (mag * gain + (64'd1 << 23)) >> 24;
                x = (diff < 0) ? -longint'(r) : longint'(r);
                x = clamp_press(x);
                acc = x * a + longint'(level[ch]) * (65536 - a);
                mag = (acc < 0) ? -acc : acc;
                q = longint'((mag + 64'd32768) >> 16);
                if (acc < 0) q = -q;
                level[ch] = PRESS_W'(clamp_press(q));
            end
            word.ch    = ch;
            word.cal   = cal_flag[ch];
            word.press = level[ch];
            pending.push_back(word);
        endfunction

        function void check_word(input logic ch, input logic cal,
                                 input logic signed [PRESS_W-1:0] press);
            t_reading want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, got channel %0d calibrated %0d pressure %0d",
                         $time, ch, cal, press);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (ch !== want.ch) begin
                $display("%0t: channel expected %0d got %0d", $time, want.ch, ch);
                errors++;
            end
            if (cal !== want.cal) begin
                $display("%0t: calibrated expected %0d got %0d", $time, want.cal, cal);
                errors++;
            end
            if (press !== want.press) begin
                $display("%0t: pressure expected %0d got %0d", $time, want.press, press);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;   // [19:0] sample
    logic [IN_USER_W-1:0]  i_s_axis_tuser = '0;   // [0] channel
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;        // [28:0] pressure
    logic [OUT_USER_W-1:0] o_m_axis_tuser;        // [0] out_channel, [1] calibrated
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pressure_tracker tracker;
    int              src_idle_pct = 0;
    int              sink_stall_pct = 0;
    int              cycles = 0;

    pressure_zero_cal_ema_filter #(
        .CHANNELS(NUM_CH)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tuser(o_m_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: check each accepted word, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            tracker.check_word(o_m_axis_tuser[0], o_m_axis_tuser[1],
                               o_m_axis_tdata[PRESS_W-1:0]);
        end
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        tracker.load_register(idx, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // valid stays high after a handshake so back-to-back words need no second assignment
    task automatic push_sample(input logic ch, input logic [SAMPLE_BITS-1:0] smp);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_DATA_W'(smp);
        i_s_axis_tuser  <= ch;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        tracker.note_sample(ch, smp);
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    initial begin
        logic                   ch;
        logic [SAMPLE_BITS-1:0] smp;
        int                     near;
        tracker = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // channel 1 starts a long calibration, channel 0 one sample of it
        set_register(CFG_CAL_SAMPLES, 32'd1023);
        set_register(CFG_GAIN, 32'hFFFF_FFFF);
        set_register(CFG_ALPHA, 32'(ALPHA_ONE));
        push_sample(1'b1, '0);
        push_sample(1'b1, SAMPLE_MAX);
        push_sample(1'b1, 20'h5A5A5);
        push_sample(1'b1, 20'hA5A5A);
        push_sample(1'b0, 20'h80000);
        settle();

        // count lowered to zero: both finish on their next word
        set_register(CFG_CAL_SAMPLES, 32'd0);
        push_sample(1'b0, 20'h80000);
        push_sample(1'b1, 20'h12345);
        push_sample(1'b0, '0);
        push_sample(1'b0, SAMPLE_MAX);
        push_sample(1'b0, 20'h80000);
        push_sample(1'b1, SAMPLE_MAX);
        push_sample(1'b1, '0);
        settle();

        set_register(CFG_GAIN, 32'd0);
        set_register(CFG_ALPHA, 32'h1FFFF);
        push_sample(1'b0, SAMPLE_MAX);
        push_sample(1'b1, '0);
        settle();

        set_register(CFG_GAIN, 32'(RST_GAIN));
        set_register(CFG_ALPHA, 32'd0);
        set_register(CFG_CAL_SAMPLES, 32'd1);
        push_sample(1'b0, SAMPLE_MAX);
        push_sample(1'b1, SAMPLE_MAX);
        settle();
        set_register(CFG_ALPHA, 32'd1);
        push_sample(1'b0, SAMPLE_MAX);
        push_sample(1'b0, SAMPLE_MAX);
        push_sample(1'b1, '0);
        settle();

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
                default: begin src_idle_pct = 29; sink_stall_pct = 29; end
            endcase
            set_register(CFG_CAL_SAMPLES, 32'($urandom_range(1023)));
            case ($urandom_range(5))
                0: set_register(CFG_GAIN, 32'd0);
                1: set_register(CFG_GAIN, 32'hFFFF_FFFF);
                2: set_register(CFG_GAIN, 32'(RST_GAIN));
                3: set_register(CFG_GAIN, 32'($urandom_range(32'(RST_GAIN) * 16)));
                default: set_register(CFG_GAIN, $urandom());
            endcase
            case ($urandom_range(6))
                0: set_register(CFG_ALPHA, 32'd0);
                1: set_register(CFG_ALPHA, 32'd1);
                2: set_register(CFG_ALPHA, 32'(ALPHA_ONE));
                3: set_register(CFG_ALPHA, 32'($urandom_range(131071, 65537)));
                4: set_register(CFG_ALPHA, 32'(RST_ALPHA));
                default: set_register(CFG_ALPHA, 32'($urandom_range(65536)));
            endcase
            for (int k = 0; k < PHASE_WORDS; k++) begin
                ch = 1'($urandom_range(1));
                case ($urandom_range(9))
                    0: smp = '0;
                    1: smp = SAMPLE_MAX;
                    2, 3, 4, 5: begin
                        // small swings around the zero offset
                        near = int'(tracker.zero_ofs[ch] >> 8) + $urandom_range(1023) - 512;
                        if (near < 0) near = 0;
                        if (near > int'(SAMPLE_MAX)) near = int'(SAMPLE_MAX);
                        smp = SAMPLE_BITS'(near);
                    end
                    default: smp = SAMPLE_BITS'($urandom());
                endcase
                push_sample(ch, smp);
            end
            settle();
        end

        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
